// File: rtl/rstf_pkg.sv
// ----------------------------------------------------------------------------
// rstf_pkg
// Shared types and constants of the rate-shaped task FIFO: item and result
// beats, action codes, and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package rstf_pkg;

    localparam int          PERIOD_BITS  = 32;
    localparam int          TASK_ID_BITS = 16;
    localparam logic [31:0] PERIOD_RESET = 32'd1000;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_DECIDE = 2'd3
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [TASK_ID_BITS-1:0]   task_id;
        logic                      core_idle;
    } t_item;

    typedef struct packed {
        logic                      assigned_valid;
        logic [TASK_ID_BITS-1:0]   assigned_id;
        logic                      slice_valid;
        logic [PERIOD_BITS-1:0]    time_left;
        logic                      dropped;
        logic                      removed;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the accepted item
        logic tick;        // advance elapsed counter
        logic add;         // append or drop
        logic decide_eval; // clear first-run flag when a release is allowed
        logic idx_clr;     // restart the queue walk at the head
        logic idx_inc;     // advance the walk index
        logic rd_next;     // read the entry after the walk index
        logic wr_shift;    // write read data back one place toward the head
        logic hit;         // matching entry found at the walk index
        logic pop;         // drop one entry from the count
        logic emit;        // build and present the result beat
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    q_empty;
        logic    core_idle;
        logic    allow;      // first run, or elapsed reached the period
        logic    match;      // read data matches the item (or decide)
        logic    scan_last;  // walk index is the last valid entry
        logic    shift_more; // entries remain behind the walk index
    } t_dp_sts;

endpackage

// File: rtl/rstf_ram.sv
// ----------------------------------------------------------------------------
// rstf_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rstf_ram #(
    parameter int   WIDTH = 16,
    parameter int   DEPTH = 16,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rstf_ctrl.sv
// ----------------------------------------------------------------------------
// rstf_ctrl
// Sequencer of the rate-shaped task FIFO: dispatches each item and walks the
// queue for remove and release (scan for the entry, then compact behind it).
// ----------------------------------------------------------------------------
module rstf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  rstf_pkg::t_dp_sts i_sts,
    output rstf_pkg::t_dp_cmd o_cmd
);
    import rstf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_TEST,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESULT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_sts.action)
                    ACT_TICK: begin
                        cmd.tick = 1'b1;
                        n_state  = ST_RESULT;
                    end
                    ACT_ADD: begin
                        cmd.add = 1'b1;
                        n_state = ST_RESULT;
                    end
                    ACT_REMOVE: begin
                        cmd.idx_clr = 1'b1;
                        n_state     = i_sts.q_empty ? ST_RESULT : ST_SCAN_RD;
                    end
                    ACT_DECIDE: begin
                        cmd.decide_eval = 1'b1;
                        cmd.idx_clr     = 1'b1;
                        if (i_sts.allow && i_sts.core_idle && !i_sts.q_empty) begin
                            n_state = ST_SCAN_RD;
                        end else begin
                            n_state = ST_RESULT;
                        end
                    end
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                priority if (i_sts.match) begin
                    cmd.hit = 1'b1;
                    n_state = ST_SHIFT_TEST;
                end else if (i_sts.scan_last) begin
                    n_state = ST_RESULT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = ST_SCAN_RD;
                end
            end
            ST_SHIFT_TEST: begin
                if (i_sts.shift_more) begin
                    n_state = ST_SHIFT_RD;
                end else begin
                    cmd.pop = 1'b1;
                    n_state = ST_RESULT;
                end
            end
            ST_SHIFT_RD: begin
                cmd.rd_next = 1'b1;
                n_state     = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                n_state      = ST_SHIFT_TEST;
            end
            ST_RESULT: begin
                cmd.emit = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);

`ifndef SYNTH
    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT) |=> (r_state == ST_IDLE))
        else $error("controller left result state for a non-idle state");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == ST_EXEC))
        else $error("accepted beat not dispatched");

    a_pop_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.hit |=> (r_state == ST_SHIFT_TEST))
        else $error("hit not followed by compaction");
`endif

endmodule

// File: rtl/rstf_dp.sv
// ----------------------------------------------------------------------------
// rstf_dp
// Datapath of the rate-shaped task FIFO: queue RAM, count, walk index,
// elapsed counter, shaping period and the result register.
// ----------------------------------------------------------------------------
module rstf_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rstf_pkg::t_item       i_item,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    input  rstf_pkg::t_dp_cmd     i_cmd,
    output rstf_pkg::t_dp_sts     o_sts,
    output logic                  o_valid,
    output rstf_pkg::t_result     o_result
);
    import rstf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PERIOD_BITS-1:0] r_period;
    logic [PERIOD_BITS-1:0] r_elapsed;
    logic                   r_first_run;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_idx;
    logic                   r_valid;

    t_action                r_action;
    logic [ID_BITS-1:0]     r_id;
    logic                   r_core_idle;
    logic                   r_a_valid;
    logic [ID_BITS-1:0]     r_a_id;
    logic                   r_dropped;
    logic                   r_removed;
    t_result                r_result;

    logic                   q_full;
    logic [CW-1:0]          idx_p1;
    logic                   below;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ID_BITS-1:0]     ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [ID_BITS-1:0]     ram_rdata;

    assign q_full = (r_count == CW'(QUEUE_DEPTH));
    assign idx_p1 = CW'(r_idx) + 1'b1;
    assign below  = (r_elapsed < r_period);

    assign ram_we    = (i_cmd.add && !q_full) || i_cmd.wr_shift;
    assign ram_waddr = i_cmd.add ? r_count[AW-1:0] : r_idx;
    assign ram_wdata = i_cmd.add ? r_id : ram_rdata;
    assign ram_raddr = i_cmd.rd_next ? idx_p1[AW-1:0] : r_idx;

    rstf_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.action     = r_action;
        o_sts.q_empty    = (r_count == '0);
        o_sts.core_idle  = r_core_idle;
        o_sts.allow      = r_first_run || !below;
        o_sts.match      = (r_action == ACT_DECIDE) || (ram_rdata == r_id);
        o_sts.scan_last  = (idx_p1 == r_count);
        o_sts.shift_more = (idx_p1 < r_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_elapsed   <= '0;
            r_first_run <= 1'b1;
            r_count     <= '0;
            r_idx       <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            // saturate at all ones
            if (i_cmd.tick && (r_elapsed != '1)) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
            if (i_cmd.add && !q_full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.decide_eval && o_sts.allow) begin
                r_first_run <= 1'b0;
            end
            if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
                if (r_action == ACT_DECIDE) begin
                    r_elapsed <= '0;
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            r_valid <= i_cmd.emit;
        end
    end

    // item payload, flags and result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= i_item.action;
            r_id        <= ID_BITS'(i_item.task_id);
            r_core_idle <= i_item.core_idle;
            r_a_valid   <= 1'b0;
            r_a_id      <= '0;
            r_dropped   <= 1'b0;
            r_removed   <= 1'b0;
        end
        if (i_cmd.add && q_full) begin
            r_dropped <= 1'b1;
        end
        if (i_cmd.hit) begin
            if (r_action == ACT_DECIDE) begin
                r_a_valid <= 1'b1;
                r_a_id    <= ram_rdata;
            end else begin
                r_removed <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_result.assigned_valid <= r_a_valid;
            r_result.assigned_id    <= TASK_ID_BITS'(r_a_id);
            r_result.slice_valid    <= !r_first_run && below;
            r_result.time_left      <= below ? (r_period - r_elapsed) : '0;
            r_result.dropped        <= r_dropped;
            r_result.removed        <= r_removed;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not shrink the queue by one entry");

    a_first_run_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_first_run |=> !r_first_run)
        else $error("first-run flag set again without reset");
`endif

endmodule

// File: rtl/rate_shaped_task_fifo.sv
// ----------------------------------------------------------------------------
// rate_shaped_task_fifo
// FIFO of task IDs whose head is released to an idle core at most once per
// shaping period; one result beat per item.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and its single result
// beat appears on o_result with o_valid high for one cycle; the receiver
// cannot stall it. Tick, add and a non-releasing decide go from execute to
// result. Remove and a releasing decide walk the queue RAM through its single
// read port: read and check states per entry scanned; test, read and write
// states per entry compacted. The shaping period is to be written through
// i_cfg_we/i_cfg_wdata only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rate_shaped_task_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rstf_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    output logic              o_valid,
    output rstf_pkg::t_result o_result
);
    import rstf_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rstf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    rstf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule
